// ----- src/lru_cache_key_value_macros.svh -----
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared concurrent assertion forms for the cache RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_KEY_VALUE_MACROS_SVH
`define LRU_CACHE_KEY_VALUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LKV_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkv assertion failed");

// Next-cycle implication, disabled during reset.
`define LKV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkv assertion failed");

`endif

// ----- src/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Widths, controller states and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int LKV_ENTRIES = 16;
  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_RESP
  } lkv_state_t;

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_SET = 1'b1
  } lkv_req_type_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
    logic load;
  } lkv_cmd_t;

  typedef struct packed {
    logic out_free;
  } lkv_sts_t;

endpackage

// ----- src/lkv_req_if.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache request channel
// Valid/ready channel carrying one get or set request per item.
// ----------------------------------------------------------------------------
interface lkv_req_if import lkv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [KEY_W-1:0]  lookup_key;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output req_type, output lookup_key, output write_data,
                  input ready);
  modport sink   (input valid, input req_type, input lookup_key, input write_data,
                  output ready);
endinterface

// ----- src/lkv_rsp_if.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface lkv_rsp_if import lkv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, output hit, output read_data, input ready);
  modport sink   (input valid, input hit, input read_data, output ready);
endinterface

// ----- src/lru_cache_key_value.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key/data store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request passes from acceptance to a loaded result through capture, a
// parallel key compare over all entries, the rank and store update (with the
// registered read of the data memory), and the load of the output register.
// The controller accepts one request at a time, so a new request is taken only
// after the previous result is loaded, and the load waits while the output
// register stays stalled. A get hit returns the stored data; a get miss or any
// set returns zero data, with hit telling whether the key was present. The store is empty after reset.
// ----------------------------------------------------------------------------
module lru_cache_key_value import lkv_pkg::*; #(
  parameter int ENTRIES = LKV_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  lkv_req_if.sink   req,
  lkv_rsp_if.source rsp
);

  lkv_cmd_t cmd;
  lkv_sts_t sts;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lkv_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req.req_type),
    .lookup_key    (req.lookup_key),
    .write_data    (req.write_data),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_hit       (rsp.hit),
    .rsp_read_data (rsp.read_data)
  );

endmodule

// ----- src/lkv_ctrl.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences capture, lookup, update and result load for one request.
// ----------------------------------------------------------------------------
module lkv_ctrl import lkv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  lkv_sts_t sts,
  output lkv_cmd_t cmd
);

  lkv_state_t state;
  lkv_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        // hold until the output register can take the item
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/lkv_datapath.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Key/valid/rank registers, data memory, match search, rank update, output.
// ----------------------------------------------------------------------------
module lkv_datapath import lkv_pkg::*; #(
  parameter int ENTRIES = LKV_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  lkv_cmd_t          cmd,
  output lkv_sts_t          sts,
  input  logic              req_type,
  input  logic [KEY_W-1:0]  lookup_key,
  input  logic [DATA_W-1:0] write_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic              rsp_hit,
  output logic [DATA_W-1:0] rsp_read_data
);

  `include "lru_cache_key_value_macros.svh"

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] OLDEST_RANK = IDX_W'(ENTRIES - 1);

  // captured request
  logic              type_q;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] wdata_q;

  // entry state
  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]   rank [ENTRIES];
  logic [KEY_W-1:0]   keys [ENTRIES];
  logic [DATA_W-1:0]  data_mem [ENTRIES];
  logic [DATA_W-1:0]  rd_data;

  // lookup results
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] old_vec;
  logic [IDX_W-1:0]   match_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   old_idx;
  logic               any_match;
  logic               any_free;
  logic [IDX_W-1:0]   tgt_next;

  logic               hit_q;
  logic [IDX_W-1:0]   tgt_q;

  logic               do_update;
  logic [IDX_W-1:0]   limit;

  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    old_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid[i] && (keys[i] == key_q);
      old_vec[i]   = valid[i] && (rank[i] == OLDEST_RANK);
    end
    // lowest index wins for match and free slot
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    // highest index wins for the oldest entry; none found leaves zero
    for (int i = 0; i < ENTRIES; i++) begin
      if (old_vec[i]) begin
        old_idx = IDX_W'(i);
      end
    end
    any_match = |match_vec;
    any_free  = ~&valid;
    if (any_match) begin
      tgt_next = match_idx;
    end else if (any_free) begin
      tgt_next = free_idx;
    end else begin
      tgt_next = old_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_q  <= req_type;
      key_q   <= lookup_key;
      wdata_q <= write_data;
    end
    if (cmd.lookup) begin
      hit_q <= any_match;
      tgt_q <= tgt_next;
    end
  end

  assign do_update = cmd.update && (hit_q || (type_q == REQ_SET));
  // a hit ages only entries more recent than it; a miss ages every valid entry
  assign limit     = rank[tgt_q];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (do_update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == tgt_q) begin
          rank[i]  <= '0;
          valid[i] <= 1'b1;
        end else if (valid[i] && (!hit_q || (rank[i] < limit))) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_update && !hit_q) begin
      keys[tgt_q] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update && (type_q == REQ_SET)) begin
      data_mem[tgt_q] <= wdata_q;
    end
    if (cmd.update && hit_q && (type_q == REQ_GET)) begin
      rd_data <= data_mem[tgt_q];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp_hit       <= hit_q;
      rsp_read_data <= (hit_q && (type_q == REQ_GET)) ? rd_data : '0;
    end
  end

  assign sts.out_free = !rsp_valid || rsp_ready;

  `LKV_ASSERT_NEXT(a_tgt_most_recent, clk, rst, do_update, valid[tgt_q] && (rank[tgt_q] == '0))
  `LKV_ASSERT_IMPL(a_miss_zero_data, clk, rst, rsp_valid && !rsp_hit, rsp_read_data == '0)
  `LKV_ASSERT_IMPL(a_full_one_oldest, clk, rst, cmd.lookup && (&valid), $countones(old_vec) == 1)

endmodule
